>>> rtl/mlev_pkg.sv
// ------------------------------------------------------------------------------------------
// mlev_pkg
// widths, codes and shared types of the mixing-length eddy viscosity core
// ------------------------------------------------------------------------------------------
`default_nettype none

package mlev_pkg;

   localparam int unsigned GRAD_W     = 32;
   localparam int unsigned LEN_W      = 24;
   localparam int unsigned OUT_W      = 48;
   localparam int unsigned DIM_W      = 2;
   localparam int unsigned FRAC_BITS  = 16;

   localparam int unsigned DMAG_W     = GRAD_W;
   localparam int unsigned OMAG_W     = GRAD_W + 1;
   localparam int unsigned DSQ_W      = 2 * DMAG_W - 1;
   localparam int unsigned OSQ_W      = 2 * OMAG_W - 1;
   localparam int unsigned NORM_W     = OSQ_W + 2;
   localparam int unsigned ROOT_W     = (NORM_W + 1) / 2;
   localparam int unsigned LSQ_W      = 2 * LEN_W;
   localparam int unsigned PART_W     = ROOT_W + LEN_W;
   localparam int unsigned PROD_W     = ROOT_W + LSQ_W;

   localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
   localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_THREE;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/mixing_length_eddy_viscosity_core.sv
// ------------------------------------------------------------------------------------------
// mixing_length_eddy_viscosity_core
// Takes one mesh cell word per cycle (nine signed velocity gradients and the mixing length)
// and returns one eddy viscosity word: the floor square root of the strain-rate norm times
// the squared mixing length, truncated and saturated to unsigned 48 bits. A new word is
// accepted in every cycle in which the output register is free or being taken. The datapath
// is the 34-stage square-root pipeline (one root bit per stage) plus four stages in front
// (magnitudes, squares, two sum levels) and three behind (two partial products, their sum,
// saturation). A stalled result holds the whole pipeline in place.
// The dimension register may be written only while no word is in flight.
// ------------------------------------------------------------------------------------------
`default_nettype none

module mixing_length_eddy_viscosity_core #(
   parameter int unsigned FRAC_BITS = mlev_pkg::FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_write_enable,
   input  logic [mlev_pkg::DIM_W-1:0]          csr_write_data,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_du_dx,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_du_dy,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_du_dz,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_dv_dx,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_dv_dy,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_dv_dz,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_dw_dx,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_dw_dy,
   input  logic signed [mlev_pkg::GRAD_W-1:0]  req_dw_dz,
   input  logic [mlev_pkg::LEN_W-1:0]          req_mix_len,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mlev_pkg::OUT_W-1:0]          rsp_eddy_viscosity
);

   localparam int unsigned DMAG_W = mlev_pkg::DMAG_W;
   localparam int unsigned OMAG_W = mlev_pkg::OMAG_W;
   localparam int unsigned DSQ_W  = mlev_pkg::DSQ_W;
   localparam int unsigned OSQ_W  = mlev_pkg::OSQ_W;
   localparam int unsigned NORM_W = mlev_pkg::NORM_W;
   localparam int unsigned ROOT_W = mlev_pkg::ROOT_W;
   localparam int unsigned LEN_W  = mlev_pkg::LEN_W;
   localparam int unsigned LSQ_W  = mlev_pkg::LSQ_W;
   localparam int unsigned PART_W = mlev_pkg::PART_W;
   localparam int unsigned PROD_W = mlev_pkg::PROD_W;
   localparam int unsigned OUT_W  = mlev_pkg::OUT_W;
   localparam int unsigned SHIFT  = 2 * FRAC_BITS;

   function automatic logic [OMAG_W-1:0] magnitude(input logic signed [OMAG_W-1:0] v);
      logic [OMAG_W-1:0] neg;
      neg = OMAG_W'(~v) + OMAG_W'(1);
      return v[OMAG_W-1] ? neg : OMAG_W'(v);
   endfunction

   logic                              pipe_advance;
   logic [mlev_pkg::DIM_W-1:0]        dimension_ff, dimension_in;
   logic                              use_two, use_three;

   logic signed [OMAG_W-1:0]          sum_vx_uy, sum_uz_wx, sum_vz_wy;

   logic                              a_valid_ff;
   logic [2:0][DMAG_W-1:0]            a_diag_ff, a_diag_in;
   logic [2:0][OMAG_W-1:0]            a_off_ff, a_off_in;
   logic [LEN_W-1:0]                  a_len_ff;

   logic                              b_valid_ff;
   logic [2:0][DSQ_W-1:0]             b_diag_sq_ff, b_diag_sq_in;
   logic [2:0][OSQ_W-1:0]             b_off_sq_ff, b_off_sq_in;
   logic [LSQ_W-1:0]                  b_len_sq_ff, b_len_sq_in;

   logic                              c_valid_ff;
   logic [NORM_W-1:0]                 c_diag_sum_ff, c_diag_sum_in;
   logic [NORM_W-1:0]                 c_off_sum_ff, c_off_sum_in;
   logic [LSQ_W-1:0]                  c_len_sq_ff;

   logic                              d_valid_ff;
   logic [NORM_W-1:0]                 d_norm_ff, d_norm_in;
   logic [LSQ_W-1:0]                  d_len_sq_ff;

   mlev_pkg::pipe_ctrl_type           sq_ctrl;
   logic                              sq_valid;
   logic [ROOT_W-1:0]                 sq_root;
   logic [LSQ_W-1:0]                  sq_len_sq;

   logic                              e_valid_ff;
   logic [PART_W-1:0]                 e_part_lo_ff, e_part_lo_in;
   logic [PART_W-1:0]                 e_part_hi_ff, e_part_hi_in;

   logic                              f_valid_ff;
   logic [PROD_W-1:0]                 f_prod_ff, f_prod_in;

   logic [PROD_W-1:0]                 g_shifted;
   logic                              g_over;
   logic                              rsp_valid_ff;
   logic [OUT_W-1:0]                  rsp_eddy_viscosity_ff, rsp_eddy_viscosity_in;

   // whole pipeline moves unless the output word is held
   assign pipe_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = !pipe_advance;

   assign dimension_in = csr_write_enable ? csr_write_data : dimension_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= mlev_pkg::DIM_RESET;
      end else begin
         dimension_ff <= dimension_in;
      end
   end

   // stage a: magnitudes, unused terms forced to zero
   assign use_two   = dimension_ff >= mlev_pkg::DIM_TWO;
   assign use_three = dimension_ff == mlev_pkg::DIM_THREE;

   assign sum_vx_uy = {req_dv_dx[DMAG_W-1], req_dv_dx} + {req_du_dy[DMAG_W-1], req_du_dy};
   assign sum_uz_wx = {req_du_dz[DMAG_W-1], req_du_dz} + {req_dw_dx[DMAG_W-1], req_dw_dx};
   assign sum_vz_wy = {req_dv_dz[DMAG_W-1], req_dv_dz} + {req_dw_dy[DMAG_W-1], req_dw_dy};

   always_comb begin
      a_diag_in[0] = DMAG_W'(magnitude({req_du_dx[DMAG_W-1], req_du_dx}));
      a_diag_in[1] = use_two ? DMAG_W'(magnitude({req_dv_dy[DMAG_W-1], req_dv_dy})) : '0;
      a_diag_in[2] = use_three ? DMAG_W'(magnitude({req_dw_dz[DMAG_W-1], req_dw_dz})) : '0;
      a_off_in[0]  = use_two ? magnitude(sum_vx_uy) : '0;
      a_off_in[1]  = use_three ? magnitude(sum_uz_wx) : '0;
      a_off_in[2]  = use_three ? magnitude(sum_vz_wy) : '0;
   end

   // stage b: squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_diag_sq_in[i] = DSQ_W'(a_diag_ff[i]) * DSQ_W'(a_diag_ff[i]);
         b_off_sq_in[i]  = OSQ_W'(a_off_ff[i]) * OSQ_W'(a_off_ff[i]);
      end
      b_len_sq_in = LSQ_W'(a_len_ff) * LSQ_W'(a_len_ff);
   end

   // stage c and d: norm with doubled diagonal terms
   assign c_diag_sum_in = NORM_W'(b_diag_sq_ff[0]) + NORM_W'(b_diag_sq_ff[1])
                        + NORM_W'(b_diag_sq_ff[2]);
   assign c_off_sum_in  = NORM_W'(b_off_sq_ff[0]) + NORM_W'(b_off_sq_ff[1])
                        + NORM_W'(b_off_sq_ff[2]);
   assign d_norm_in     = (c_diag_sum_ff << 1) + c_off_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         a_diag_ff     <= a_diag_in;
         a_off_ff      <= a_off_in;
         a_len_ff      <= req_mix_len;
         b_diag_sq_ff  <= b_diag_sq_in;
         b_off_sq_ff   <= b_off_sq_in;
         b_len_sq_ff   <= b_len_sq_in;
         c_diag_sum_ff <= c_diag_sum_in;
         c_off_sum_ff  <= c_off_sum_in;
         c_len_sq_ff   <= b_len_sq_ff;
         d_norm_ff     <= d_norm_in;
         d_len_sq_ff   <= c_len_sq_ff;
      end
   end

   assign sq_ctrl = '{advance: pipe_advance, valid: d_valid_ff};

   mlev_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_ctrl     (sq_ctrl),
      .in_radicand (d_norm_ff),
      .in_len_sq   (d_len_sq_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_len_sq  (sq_len_sq)
   );

   // stage e and f: root times squared length in two halves
   assign e_part_lo_in = PART_W'(sq_root) * PART_W'(sq_len_sq[LEN_W-1:0]);
   assign e_part_hi_in = PART_W'(sq_root) * PART_W'(sq_len_sq[LSQ_W-1:LEN_W]);
   assign f_prod_in    = PROD_W'(e_part_lo_ff) + (PROD_W'(e_part_hi_ff) << LEN_W);

   // stage g: truncate and saturate
   assign g_shifted             = f_prod_ff >> SHIFT;
   assign g_over                = |g_shifted[PROD_W-1:OUT_W];
   assign rsp_eddy_viscosity_in = g_over ? '1 : g_shifted[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         e_valid_ff   <= sq_valid;
         f_valid_ff   <= e_valid_ff;
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         e_part_lo_ff          <= e_part_lo_in;
         e_part_hi_ff          <= e_part_hi_in;
         f_prod_ff             <= f_prod_in;
         rsp_eddy_viscosity_ff <= rsp_eddy_viscosity_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_eddy_viscosity = rsp_eddy_viscosity_ff;

`ifndef SYNTHESIS
   hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !pipe_advance |=> $stable({a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff,
                                 e_valid_ff, f_valid_ff, rsp_valid_ff}))
      else $error("pipeline valid bits moved while stalled");

   zero_length_product: assert property (@(posedge clock) disable iff (reset)
      pipe_advance && sq_valid && sq_len_sq == '0 |=> e_part_lo_ff == '0 && e_part_hi_ff == '0)
      else $error("zero mixing length gave a nonzero product");

   norm_no_wrap: assert property (@(posedge clock) disable iff (reset)
      pipe_advance && c_valid_ff |=> d_norm_ff >= $past(c_off_sum_ff))
      else $error("strain-rate norm wrapped");
`endif

endmodule

`default_nettype wire

>>> rtl/mlev_isqrt.sv
// ------------------------------------------------------------------------------------------
// mlev_isqrt
// pipelined integer square root, one root bit per stage, carries the squared length
// ------------------------------------------------------------------------------------------
`default_nettype none

module mlev_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  mlev_pkg::pipe_ctrl_type      in_ctrl,
   input  logic [mlev_pkg::NORM_W-1:0]  in_radicand,
   input  logic [mlev_pkg::LSQ_W-1:0]   in_len_sq,
   output logic                         out_valid,
   output logic [mlev_pkg::ROOT_W-1:0]  out_root,
   output logic [mlev_pkg::LSQ_W-1:0]   out_len_sq
);

   localparam int unsigned STAGES  = mlev_pkg::ROOT_W;
   localparam int unsigned TRIAL_W = mlev_pkg::NORM_W + 2;

   logic [STAGES-1:0]               valid_ff;
   logic [mlev_pkg::NORM_W-1:0]     rem_ff    [STAGES];
   logic [mlev_pkg::ROOT_W-1:0]     root_ff   [STAGES];
   logic [mlev_pkg::LSQ_W-1:0]      len_sq_ff [STAGES];
   logic [mlev_pkg::NORM_W-1:0]     rem_in    [STAGES];
   logic [mlev_pkg::ROOT_W-1:0]     root_in   [STAGES];
   logic [mlev_pkg::LSQ_W-1:0]      len_sq_in [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int unsigned BIT = STAGES - 1 - k;
      logic [mlev_pkg::NORM_W-1:0] rem_prev;
      logic [mlev_pkg::ROOT_W-1:0] root_prev;
      logic [TRIAL_W-1:0]          rem_ext;
      logic [TRIAL_W-1:0]          trial;
      logic                        take;

      if (k == 0) begin : g_first
         assign rem_prev     = in_radicand;
         assign root_prev    = '0;
         assign len_sq_in[k] = in_len_sq;
      end else begin : g_next
         assign rem_prev     = rem_ff[k-1];
         assign root_prev    = root_ff[k-1];
         assign len_sq_in[k] = len_sq_ff[k-1];
      end

      // (root + 2^b)^2 <= n  <=>  n - root^2 >= root * 2^(b+1) + 2^(2b)
      assign rem_ext    = TRIAL_W'(rem_prev);
      assign trial      = (TRIAL_W'(root_prev) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
      assign take       = rem_ext >= trial;
      assign rem_in[k]  = take ? mlev_pkg::NORM_W'(rem_ext - trial) : rem_prev;
      assign root_in[k] = take ? (root_prev | (mlev_pkg::ROOT_W'(1) << BIT)) : root_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (in_ctrl.advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_ctrl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctrl.advance) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k]    <= rem_in[k];
            root_ff[k]   <= root_in[k];
            len_sq_ff[k] <= len_sq_in[k];
         end
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_root   = root_ff[STAGES-1];
   assign out_len_sq = len_sq_ff[STAGES-1];

`ifndef SYNTHESIS
   root_is_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> rem_ff[STAGES-1] <= mlev_pkg::NORM_W'({root_ff[STAGES-1], 1'b0}))
      else $error("root pipeline left a remainder above twice the root");

   hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !in_ctrl.advance |=> $stable(valid_ff) && $stable(root_ff[STAGES-1]))
      else $error("root pipeline moved while held");
`endif

endmodule

`default_nettype wire
